>>> hdl/ewbcs_pkg.sv
// ----------------------------------------------------------------------------
// ewbcs_pkg
// Shared types and constants of the equal-width bin counting sort.
// ----------------------------------------------------------------------------
package ewbcs_pkg;

    localparam int VAL_W = 32;
    localparam int BIN_W = 6;
    localparam int POS_W = 16;
    localparam int TABLE_DEPTH = 64;

    // opcodes
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_COUNT = 2'd1;
    localparam logic [1:0] OP_FINAL = 2'd2;
    localparam logic [1:0] OP_PLACE = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_RANGE   = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_TOOMANY = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    // register indexes
    localparam logic [1:0] REG_MIN  = 2'd0;
    localparam logic [1:0] REG_MAX  = 2'd1;
    localparam logic [1:0] REG_STEP = 2'd2;

    localparam logic [BIN_W-1:0] NAN_MARK = 6'd63;

    typedef struct packed {
        logic [1:0]              op;
        logic signed [VAL_W-1:0] sample;
        logic                    is_nan;
    } cmd_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] min_value;
        logic signed [VAL_W-1:0] max_value;
        logic [VAL_W-1:0]        bin_width;
    } cfg_t;

endpackage

>>> hdl/ewbcs_front.sv
// ----------------------------------------------------------------------------
// ewbcs_front
// Command intake: takes transactions and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module ewbcs_front
    import ewbcs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              opcode,
    input  logic signed [VAL_W-1:0] sample,
    input  logic                    is_nan,
    output cmd_t                    cmd,
    output logic                    cmd_valid,
    input  logic                    cmd_pop
);

    cmd_t       ent_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign busy      = (cnt_reg == 2'd2);
    assign push      = start && !busy;
    assign pop       = cmd_pop && (cnt_reg != 2'd0);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = ent_reg[rd_ptr_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg].op     <= opcode;
            ent_reg[wr_ptr_reg].sample <= sample;
            // a missing value only matters to count and place
            ent_reg[wr_ptr_reg].is_nan <= is_nan && (opcode != OP_CLEAR)
                                          && (opcode != OP_FINAL);
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("queue count out of range");
    a_busy_full: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> cmd_valid)
        else $error("busy with empty queue");
    a_pop_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd1 && pop && !push) |=> !cmd_valid)
        else $error("queue not empty after last pop");
`endif

endmodule

>>> hdl/ewbcs_div.sv
// ----------------------------------------------------------------------------
// ewbcs_div
// Restoring divider, one quotient bit per cycle, 33 bit by 32 bit.
// ----------------------------------------------------------------------------
module ewbcs_div
    import ewbcs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             div_start,
    input  logic [VAL_W:0]   dividend,
    input  logic [VAL_W-1:0] divisor,
    output logic             div_done,
    output logic [VAL_W:0]   quotient
);

    logic [VAL_W:0]   dvd_reg;
    logic [VAL_W:0]   rem_reg;
    logic [VAL_W-1:0] dsr_reg;
    logic [5:0]       cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [VAL_W:0]   rem_s;
    logic             ge;

    // one restoring step
    assign rem_s    = {rem_reg[VAL_W-1:0], dvd_reg[VAL_W]};
    assign ge       = (rem_s >= {1'b0, dsr_reg});
    assign div_done = done_reg;
    assign quotient = dvd_reg;

    // operand and partial remainder
    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? (rem_s - {1'b0, dsr_reg}) : rem_s;
            dvd_reg <= {dvd_reg[VAL_W-1:0], ge};
        end
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (div_start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(VAL_W))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

`ifndef ASSERT_OFF
    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> !run_reg)
        else $error("divider done while running");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> (cnt_reg <= 6'(VAL_W)))
        else $error("divider step count overrun");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |=> !div_done)
        else $error("divider done longer than one cycle");
`endif

endmodule

>>> hdl/ewbcs_back.sv
// ----------------------------------------------------------------------------
// ewbcs_back
// Command execution: histogram, prefix sums and slot assignment.
// ----------------------------------------------------------------------------
module ewbcs_back
    import ewbcs_pkg::*;
#(
    parameter int MAX_BINS  = 63,
    parameter int MAX_ITEMS = 65535
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  cmd_t             cmd,
    input  logic             cmd_valid,
    output logic             cmd_pop,
    output logic             div_start,
    output logic [VAL_W:0]   dividend,
    input  logic             div_done,
    input  logic [VAL_W:0]   quotient,
    output logic             result_valid,
    output logic [2:0]       status,
    output logic [BIN_W-1:0] bin_index,
    output logic [POS_W-1:0] position,
    output logic             last
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_DIV1  = 4'd2;
    localparam logic [3:0] S_DIV2  = 4'd3;
    localparam logic [3:0] S_EXE   = 4'd4;
    localparam logic [3:0] S_FRD   = 4'd5;
    localparam logic [3:0] S_FACC  = 4'd6;
    localparam logic [3:0] S_FLAST = 4'd7;

    logic [3:0]       state_reg;
    cmd_t             cmd_reg;
    logic [BIN_W-1:0] ix_reg;
    logic [BIN_W-1:0] idx_reg;
    logic [BIN_W-1:0] nb_reg;
    logic [POS_W-1:0] acc_reg;
    logic [POS_W-1:0] nan_base_reg;
    logic [POS_W-1:0] nan_placed_reg;
    logic [POS_W-1:0] total_reg;
    logic [6:0]       bins_in_use_reg;
    logic             finalized_reg;
    logic [TABLE_DEPTH-1:0] bin_vld_reg;

    // histogram and slot tables
    logic [POS_W-1:0] bin_mem  [TABLE_DEPTH];
    logic [POS_W-1:0] next_mem [TABLE_DEPTH];
    logic [POS_W-1:0] end_mem  [TABLE_DEPTH];
    logic [POS_W-1:0] bin_rd_reg;
    logic             vld_rd_reg;
    logic [POS_W-1:0] next_rd_reg;
    logic [POS_W-1:0] end_rd_reg;

    logic             cfg_empty;
    logic             out_range;
    logic             too_many;
    logic [VAL_W:0]   span;
    logic [VAL_W:0]   offset;
    logic [BIN_W-1:0] rd_addr;
    logic [POS_W-1:0] cnt_eff;
    logic [POS_W:0]   nan_slot;
    logic             count_ok;
    logic             place_ok;
    logic             bin_we;
    logic             next_we;
    logic [BIN_W-1:0] next_waddr;
    logic [POS_W-1:0] next_wdata;
    logic             end_we;

    // configuration checks
    assign cfg_empty = (cfg.min_value >= cfg.max_value) || (cfg.bin_width == '0);
    assign out_range = (cmd_reg.sample < cfg.min_value) || (cmd_reg.sample > cfg.max_value);
    assign span      = {cfg.max_value[VAL_W-1], cfg.max_value}
                       - {cfg.min_value[VAL_W-1], cfg.min_value};
    assign offset    = {cfg.max_value[VAL_W-1], cfg.max_value}
                       - {cmd_reg.sample[VAL_W-1], cmd_reg.sample};
    assign too_many  = (quotient >= (VAL_W+1)'(MAX_BINS));
    assign nan_slot  = {1'b0, nan_base_reg} + {1'b0, nan_placed_reg};

    // divider requests: bin count first, then bin of the value
    assign div_start = (state_reg == S_DEC && !cfg_empty && !cmd_reg.is_nan
                        && cmd_reg.op != OP_CLEAR)
                    || (state_reg == S_DIV1 && div_done && !too_many
                        && cmd_reg.op != OP_FINAL && !out_range);
    assign dividend  = (state_reg == S_DEC) ? span : offset;
    assign cmd_pop   = (state_reg == S_IDLE) && cmd_valid;

    // table access control
    assign rd_addr  = (state_reg == S_DIV2) ? quotient[BIN_W-1:0] : idx_reg;
    assign cnt_eff  = vld_rd_reg ? bin_rd_reg : '0;
    assign count_ok = (total_reg < POS_W'(MAX_ITEMS)) && (bin_rd_reg != '1 || !vld_rd_reg);
    assign place_ok = finalized_reg && ({1'b0, ix_reg} < bins_in_use_reg)
                      && (next_rd_reg < end_rd_reg);
    assign bin_we   = (state_reg == S_EXE) && (cmd_reg.op == OP_COUNT) && count_ok;
    assign end_we   = (state_reg == S_FACC);
    assign next_we  = end_we || ((state_reg == S_EXE) && (cmd_reg.op == OP_PLACE) && place_ok);
    assign next_waddr = end_we ? idx_reg : ix_reg;
    assign next_wdata = end_we ? acc_reg : next_rd_reg + 16'd1;

    // table memories
    always_ff @(posedge clk)
    begin
        if (bin_we)
            bin_mem[ix_reg] <= cnt_eff + 16'd1;
        if (next_we)
            next_mem[next_waddr] <= next_wdata;
        if (end_we)
            end_mem[idx_reg] <= acc_reg + cnt_eff;
        bin_rd_reg  <= bin_mem[rd_addr];
        vld_rd_reg  <= bin_vld_reg[rd_addr];
        next_rd_reg <= next_mem[rd_addr];
        end_rd_reg  <= end_mem[rd_addr];
    end

    // command sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cmd_reg         <= '0;
            ix_reg          <= '0;
            idx_reg         <= '0;
            nb_reg          <= '0;
            acc_reg         <= '0;
            nan_base_reg    <= '0;
            nan_placed_reg  <= '0;
            total_reg       <= '0;
            bins_in_use_reg <= '0;
            finalized_reg   <= 1'b0;
            bin_vld_reg     <= '0;
            result_valid    <= 1'b0;
            status          <= ST_OK;
            bin_index       <= '0;
            position        <= '0;
            last            <= 1'b0;
        end
        else
        begin
            result_valid <= 1'b0;
            status       <= ST_OK;
            bin_index    <= '0;
            position     <= '0;
            last         <= 1'b1;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cmd_reg   <= cmd;
                        state_reg <= S_DEC;
                    end
                end
                S_DEC:
                begin
                    state_reg <= S_IDLE;
                    unique case (cmd_reg.op)
                        OP_CLEAR:
                        begin
                            bin_vld_reg     <= '0;
                            nan_base_reg    <= '0;
                            nan_placed_reg  <= '0;
                            total_reg       <= '0;
                            bins_in_use_reg <= '0;
                            finalized_reg   <= 1'b0;
                            result_valid    <= 1'b1;
                        end
                        OP_FINAL:
                        begin
                            nan_placed_reg <= '0;
                            if (cfg_empty)
                            begin
                                finalized_reg   <= 1'b1;
                                bins_in_use_reg <= '0;
                                nan_base_reg    <= '0;
                                result_valid    <= 1'b1;
                                status          <= ST_EMPTY;
                            end
                            else
                                state_reg <= S_DIV1;
                        end
                        OP_COUNT, OP_PLACE:
                        begin
                            if (cmd_reg.is_nan)
                            begin
                                result_valid <= 1'b1;
                                bin_index    <= NAN_MARK;
                                if (cmd_reg.op == OP_PLACE)
                                begin
                                    if (!finalized_reg)
                                        status <= ST_TOOMANY;
                                    else if (nan_slot >= (POS_W+1)'(MAX_ITEMS))
                                        status <= ST_FULL;
                                    else
                                    begin
                                        nan_placed_reg <= nan_placed_reg + 16'd1;
                                        position       <= nan_slot[POS_W-1:0];
                                    end
                                end
                            end
                            else if (cfg_empty)
                            begin
                                result_valid <= 1'b1;
                                status       <= ST_EMPTY;
                            end
                            else
                                state_reg <= S_DIV1;
                        end
                        default:
                        begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_DIV1:
                begin
                    if (div_done)
                    begin
                        nb_reg <= quotient[BIN_W-1:0] + 6'd1;
                        if (too_many)
                        begin
                            result_valid <= 1'b1;
                            status       <= ST_TOOMANY;
                            state_reg    <= S_IDLE;
                            if (cmd_reg.op == OP_FINAL)
                            begin
                                finalized_reg   <= 1'b0;
                                bins_in_use_reg <= '0;
                            end
                        end
                        else if (cmd_reg.op == OP_FINAL)
                        begin
                            idx_reg   <= '0;
                            acc_reg   <= '0;
                            state_reg <= S_FRD;
                        end
                        else if (out_range)
                        begin
                            result_valid <= 1'b1;
                            status       <= ST_RANGE;
                            state_reg    <= S_IDLE;
                        end
                        else
                            state_reg <= S_DIV2;
                    end
                end
                S_DIV2:
                begin
                    if (div_done)
                    begin
                        ix_reg    <= quotient[BIN_W-1:0];
                        state_reg <= S_EXE;
                    end
                end
                S_EXE:
                begin
                    result_valid <= 1'b1;
                    bin_index    <= ix_reg;
                    state_reg    <= S_IDLE;
                    if (cmd_reg.op == OP_COUNT)
                    begin
                        if (count_ok)
                        begin
                            bin_vld_reg[ix_reg] <= 1'b1;
                            total_reg           <= total_reg + 16'd1;
                            finalized_reg       <= 1'b0;
                            bins_in_use_reg     <= '0;
                        end
                        else
                            status <= ST_FULL;
                    end
                    else
                    begin
                        if (!finalized_reg || ({1'b0, ix_reg} >= bins_in_use_reg))
                            status <= ST_TOOMANY;
                        else if (!place_ok)
                            status <= ST_FULL;
                        else
                            position <= next_rd_reg;
                    end
                end
                S_FRD:
                begin
                    state_reg <= S_FACC;
                end
                S_FACC:
                begin
                    result_valid <= 1'b1;
                    bin_index    <= idx_reg;
                    position     <= acc_reg;
                    last         <= 1'b0;
                    acc_reg      <= acc_reg + cnt_eff;
                    idx_reg      <= idx_reg + 6'd1;
                    if (idx_reg == nb_reg - 6'd1)
                        state_reg <= S_FLAST;
                    else
                        state_reg <= S_FRD;
                end
                S_FLAST:
                begin
                    result_valid    <= 1'b1;
                    bin_index       <= nb_reg;
                    position        <= acc_reg;
                    nan_base_reg    <= acc_reg;
                    bins_in_use_reg <= {1'b0, nb_reg};
                    finalized_reg   <= 1'b1;
                    state_reg       <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_bins_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bins_in_use_reg <= 7'(MAX_BINS))
        else $error("bins in use beyond capacity");
    a_unfinalized_no_bins: assert property (@(posedge clk) disable iff (!rst_n)
        !finalized_reg |-> (bins_in_use_reg == '0))
        else $error("bins in use without finalize");
    a_mid_entry_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |-> (status == ST_OK))
        else $error("intermediate offset entry with error status");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> (state_reg == S_DEC))
        else $error("command taken outside idle");
`endif

endmodule

>>> hdl/equal_width_bin_counting_sort.sv
// ----------------------------------------------------------------------------
// equal_width_bin_counting_sort
// Counting sort of Q16.16 values into equal-width bins, top level.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; up to two commands
// queue while an earlier one runs. Each result is on the outputs for one
// cycle, marked by result_valid, and must be taken at once; finalize entries
// for bins each follow a histogram read state. Clear and missing-value count
// or place finish in the decode state. A numeric count or place makes two
// passes through the shared one-bit-per-cycle divider (bin count, then bin
// of the value, 33 steps each) and one table read-modify-write. Finalize
// makes one divider pass, then one histogram read per bin. An empty config,
// too many bins or an out-of-range value ends a command early. No clearing
// pass follows reset; configuration writes are always accepted.
module equal_width_bin_counting_sort
    import ewbcs_pkg::*;
#(
    parameter int MAX_BINS  = 63,
    parameter int MAX_ITEMS = 65535
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              opcode,
    input  logic signed [VAL_W-1:0] sample,
    input  logic                    is_nan,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [VAL_W-1:0]        cfg_data,
    output logic                    result_valid,
    output logic [2:0]              status,
    output logic [BIN_W-1:0]        bin_index,
    output logic [POS_W-1:0]        position,
    output logic                    last
);

    cfg_t           cfg_reg;
    cmd_t           cmd;
    logic           cmd_valid;
    logic           cmd_pop;
    logic           div_start;
    logic [VAL_W:0] dividend;
    logic           div_done;
    logic [VAL_W:0] quotient;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_value <= 32'sd0;
            cfg_reg.max_value <= 32'sd65536;
            cfg_reg.bin_width <= 32'd65536;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MIN:  cfg_reg.min_value <= cfg_data;
                REG_MAX:  cfg_reg.max_value <= cfg_data;
                REG_STEP: cfg_reg.bin_width <= cfg_data;
                default:  cfg_reg <= cfg_reg;
            endcase
        end
    end

    ewbcs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .opcode    (opcode),
        .sample    (sample),
        .is_nan    (is_nan),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    ewbcs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .div_start (div_start),
        .dividend  (dividend),
        .divisor   (cfg_reg.bin_width),
        .div_done  (div_done),
        .quotient  (quotient)
    );

    ewbcs_back #(
        .MAX_BINS  (MAX_BINS),
        .MAX_ITEMS (MAX_ITEMS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .cmd          (cmd),
        .cmd_valid    (cmd_valid),
        .cmd_pop      (cmd_pop),
        .div_start    (div_start),
        .dividend     (dividend),
        .div_done     (div_done),
        .quotient     (quotient),
        .result_valid (result_valid),
        .status       (status),
        .bin_index    (bin_index),
        .position     (position),
        .last         (last)
    );

endmodule

>>> test/tb_equal_width_bin_counting_sort.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_equal_width_bin_counting_sort
// Self-checking bench: clear/count/finalize/place sequences under directed
// and random configurations, checked against an in-bench histogram model.
// ----------------------------------------------------------------------------
module tb_equal_width_bin_counting_sort;
    import ewbcs_pkg::*;

    localparam int LIM_BINS  = 63;
    localparam int LIM_ITEMS = 65535;
    localparam int SETTLE    = 300;

    typedef struct packed {
        logic [2:0]       st;
        logic [BIN_W-1:0] bin;
        logic [POS_W-1:0] pos;
        logic             lst;
    } sort_res_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic [1:0]              opcode;
    logic signed [VAL_W-1:0] sample;
    logic                    is_nan;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [1:0]              cfg_index;
    logic [VAL_W-1:0]        cfg_data;
    logic                    result_valid;
    logic [2:0]              status;
    logic [BIN_W-1:0]        bin_index;
    logic [POS_W-1:0]        position;
    logic                    last;

    // histogram model state
    longint    lo_val, hi_val, step_val;
    int        hist [TABLE_DEPTH];
    int        slot_nxt [TABLE_DEPTH];
    int        slot_end [TABLE_DEPTH];
    int        nan_base, nan_cnt, num_total, bins_used;
    bit        is_final;
    sort_res_t slot_q [$];
    int        errors;
    bit        no_idle;

    equal_width_bin_counting_sort dut (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

    // bin count check: 0 ok, 2 empty, 3 too many
    function automatic int cfg_check(output longint nb);
        nb = 0;
        if (lo_val >= hi_val || step_val == 0)
            return ST_EMPTY;
        nb = (hi_val - lo_val) / step_val + 1;
        if (nb > LIM_BINS)
            return ST_TOOMANY;
        return ST_OK;
    endfunction

    function automatic int find_bin(longint v, output longint ix);
        longint nb;
        int     st;
        ix = 0;
        st = cfg_check(nb);
        if (st != ST_OK)
            return st;
        if (v < lo_val || v > hi_val)
            return ST_RANGE;
        ix = (hi_val - v) / step_val;
        return ST_OK;
    endfunction

    function automatic void push_res(int st, longint bin, longint pos, bit lst);
        sort_res_t r;
        r.st  = st[2:0];
        r.bin = bin[BIN_W-1:0];
        r.pos = pos[POS_W-1:0];
        r.lst = lst;
        slot_q.push_back(r);
    endfunction

    function automatic void clear_hist();
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            hist[i] = 0;
            slot_nxt[i] = 0;
            slot_end[i] = 0;
        end
        nan_base = 0;
        nan_cnt = 0;
        num_total = 0;
        bins_used = 0;
        is_final = 0;
    endfunction

    // expected results of one accepted command
    function automatic void predict_sort(logic [1:0] op, logic signed [31:0] v, logic nan);
        longint ix, nb, acc;
        int     st, slot;
        case (op)
            OP_CLEAR:
            begin
                clear_hist();
                push_res(ST_OK, 0, 0, 1);
            end
            OP_COUNT:
            begin
                if (nan)
                    push_res(ST_OK, NAN_MARK, 0, 1);
                else
                begin
                    st = find_bin(longint'(v), ix);
                    if (st != ST_OK)
                        push_res(st, 0, 0, 1);
                    else if (num_total >= LIM_ITEMS || hist[ix] >= 16'hFFFF)
                        push_res(ST_FULL, ix, 0, 1);
                    else
                    begin
                        hist[ix]++;
                        num_total++;
                        is_final = 0;
                        bins_used = 0;
                        push_res(ST_OK, ix, 0, 1);
                    end
                end
            end
            OP_FINAL:
            begin
                st = cfg_check(nb);
                nan_cnt = 0;
                if (st == ST_EMPTY)
                begin
                    is_final = 1;
                    bins_used = 0;
                    nan_base = 0;
                    push_res(ST_EMPTY, 0, 0, 1);
                end
                else if (st == ST_TOOMANY)
                begin
                    is_final = 0;
                    bins_used = 0;
                    push_res(ST_TOOMANY, 0, 0, 1);
                end
                else
                begin
                    acc = 0;
                    for (int i = 0; i < nb; i++)
                    begin
                        slot_nxt[i] = int'(acc);
                        push_res(ST_OK, i, acc, 0);
                        acc += hist[i];
                        slot_end[i] = int'(acc);
                    end
                    nan_base = int'(acc);
                    push_res(ST_OK, nb, acc, 1);
                    bins_used = int'(nb);
                    is_final = 1;
                end
            end
            default:
            begin
                if (nan)
                begin
                    slot = nan_base + nan_cnt;
                    if (!is_final)
                        push_res(ST_TOOMANY, NAN_MARK, 0, 1);
                    else if (slot >= LIM_ITEMS)
                        push_res(ST_FULL, NAN_MARK, 0, 1);
                    else
                    begin
                        nan_cnt++;
                        push_res(ST_OK, NAN_MARK, slot, 1);
                    end
                end
                else
                begin
                    st = find_bin(longint'(v), ix);
                    if (st != ST_OK)
                        push_res(st, ix, 0, 1);
                    else if (!is_final || ix >= bins_used)
                        push_res(ST_TOOMANY, ix, 0, 1);
                    else if (slot_nxt[ix] >= slot_end[ix])
                        push_res(ST_FULL, ix, 0, 1);
                    else
                    begin
                        push_res(ST_OK, ix, slot_nxt[ix], 1);
                        slot_nxt[ix]++;
                    end
                end
            end
        endcase
    endfunction

    // result checker
    always @(posedge clk)
    begin
        sort_res_t want;
        if (rst_n && result_valid)
        begin
            if (slot_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result st=%0d bin=%0d pos=%0d last=%0b",
                         $time, status, bin_index, position, last);
            end
            else
            begin
                want = slot_q.pop_front();
                if (status !== want.st || bin_index !== want.bin ||
                    position !== want.pos || last !== want.lst)
                begin
                    errors++;
                    $display("%0t: expected st=%0d bin=%0d pos=%0d last=%0b, got st=%0d bin=%0d pos=%0d last=%0b",
                             $time, want.st, want.bin, want.pos, want.lst,
                             status, bin_index, position, last);
                end
            end
        end
    end

    // one command transaction
    task automatic send_cmd(logic [1:0] op, logic signed [31:0] v, logic nan);
        @(negedge clk);
        if (!no_idle && $urandom_range(0, 99) < 30)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        start  <= 1'b1;
        opcode <= op;
        sample <= v;
        is_nan <= nan;
        do
            @(posedge clk);
        while (busy);
        predict_sort(op, v, nan);
    endtask

    // idle the command port, then wait until every expected result has arrived
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (slot_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_MIN:  lo_val = longint'($signed(data));
            REG_MAX:  hi_val = longint'($signed(data));
            REG_STEP: step_val = longint'({32'd0, data});
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_cfg(longint mn, longint mx, longint st);
        drain();
        write_reg(REG_MIN, mn[31:0]);
        write_reg(REG_MAX, mx[31:0]);
        write_reg(REG_STEP, st[31:0]);
    endtask

    // default configuration: two bins over [0, 1.0]
    task automatic test_defaults();
        send_cmd(OP_CLEAR, 0, 0);
        send_cmd(OP_COUNT, 0, 0);
        send_cmd(OP_COUNT, 32'sh0001_0000, 0);
        send_cmd(OP_COUNT, 32'sh0000_8000, 0);
        send_cmd(OP_COUNT, -1, 0);
        send_cmd(OP_COUNT, 32'sh0001_0001, 0);
        send_cmd(OP_COUNT, 0, 1);
        send_cmd(OP_PLACE, 0, 0);
        send_cmd(OP_PLACE, 0, 1);
        send_cmd(OP_FINAL, 0, 0);
        send_cmd(OP_PLACE, 32'sh0000_8000, 0);
        send_cmd(OP_PLACE, 0, 0);
        send_cmd(OP_PLACE, 32'sh0001_0000, 0);
        send_cmd(OP_PLACE, 0, 0);
        send_cmd(OP_PLACE, 0, 1);
        send_cmd(OP_PLACE, 0, 1);
        send_cmd(OP_PLACE, 32'sh7FFF_FFFF, 0);
    endtask

    // empty, too-many-bins and full-range configurations
    task automatic test_config_edges();
        set_cfg(65536, 65536, 65536);
        send_cmd(OP_COUNT, 65536, 0);
        send_cmd(OP_FINAL, 0, 0);
        send_cmd(OP_PLACE, 0, 1);
        send_cmd(OP_PLACE, 0, 0);
        set_cfg(0, 65536, 0);
        send_cmd(OP_FINAL, 0, 0);
        set_cfg(0, 65536, 1);
        send_cmd(OP_COUNT, 5, 0);
        send_cmd(OP_FINAL, 0, 0);
        send_cmd(OP_PLACE, 5, 0);
        set_cfg(-2147483648, 2147483647, 32'hFFFF_FFFF);
        send_cmd(OP_CLEAR, 0, 0);
        send_cmd(OP_COUNT, 32'sh8000_0000, 0);
        send_cmd(OP_COUNT, 32'sh7FFF_FFFF, 0);
        send_cmd(OP_FINAL, 0, 0);
        send_cmd(OP_PLACE, 32'sh8000_0000, 0);
        send_cmd(OP_PLACE, 32'sh7FFF_FFFF, 0);
        set_cfg(0, 62, 1);
        send_cmd(OP_FINAL, 0, 0);
    endtask

    // random sorting rounds with some noise commands
    task automatic test_random_sorts();
        longint            mn, mx, st, span, k;
        logic signed [31:0] vals [$];
        logic              nans [$];
        logic signed [31:0] v;
        int                n, sent;
        sent = 0;
        while (sent < 330)
        begin
            no_idle = (sent < 60);
            st = ($urandom_range(0, 3) == 0) ? longint'($urandom) + 1
                                            : longint'($urandom_range(1, 32'h0010_0000));
            if (st > 32'hFFFF_FFFF)
                st = 32'hFFFF_FFFF;
            k = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 8);
            mn = longint'($signed($urandom));
            mx = mn + st * (k - 1) + longint'($urandom_range(0, 32'(st - 1)));
            if (mx > 2147483647)
                mx = 2147483647;
            if ($urandom_range(0, 9) == 0)
                mx = mn - longint'($urandom_range(0, 10));
            if (mx < -2147483648)
                mx = -2147483648;
            set_cfg(mn, mx, st);
            span = mx - mn;
            vals.delete();
            nans.delete();
            n = $urandom_range(3, 12);
            for (int i = 0; i < n; i++)
            begin
                if (span >= 0 && $urandom_range(0, 9) < 8)
                    v = 32'(mn + longint'({$urandom, $urandom} % (span + 1)));
                else
                    v = $urandom;
                vals.push_back(v);
                nans.push_back($urandom_range(0, 7) == 0);
            end
            send_cmd(OP_CLEAR, $urandom, $urandom_range(0, 1));
            foreach (vals[i])
                send_cmd(OP_COUNT, vals[i], nans[i]);
            if ($urandom_range(0, 5) == 0)
                send_cmd(2'($urandom_range(1, 3)), $urandom, $urandom_range(0, 1));
            send_cmd(OP_FINAL, $urandom, $urandom_range(0, 1));
            vals.shuffle();
            foreach (vals[i])
                send_cmd(OP_PLACE, vals[i], nans[i]);
            if ($urandom_range(0, 3) == 0)
                send_cmd(OP_PLACE, vals[0], $urandom_range(0, 1));
            sent += 2 * n + 3;
        end
        no_idle = 0;
    endtask

    // stimulus sequence
    initial
    begin
        errors = 0;
        no_idle = 0;
        start = 1'b0;
        opcode = OP_CLEAR;
        sample = '0;
        is_nan = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_MIN;
        cfg_data = '0;
        lo_val = 0;
        hi_val = 65536;
        step_val = 65536;
        clear_hist();
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_defaults();
        test_config_edges();
        test_random_sorts();
        drain();
        repeat (SETTLE) @(negedge clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
